/* rtl/llss_pkg.sv */
// Shared types, codes and helpers of the least loaded server selector.
package llss_pkg;

   localparam int CNT_W = 32;

   // Command codes carried on req_tuser
   localparam logic [1:0] CMD_DISPATCH = 2'd0;
   localparam logic [1:0] CMD_HEALTH   = 2'd1;
   localparam logic [1:0] CMD_OUTCOME  = 2'd2;

   // Connection outcome codes
   localparam logic [1:0] OUT_CONNECT_FAIL = 2'd1;
   localparam logic [1:0] OUT_RELAY_FAIL   = 2'd2;

   // Configuration register indexes
   localparam logic [7:0] CSR_ACTIVE_SERVERS   = 8'd0;
   localparam logic [7:0] CSR_RECHECK_INTERVAL = 8'd1;

   localparam logic [15:0] DCOUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [CNT_W-1:0] errors;
      logic [CNT_W-1:0] requests;
   } entry_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

/* rtl/least_loaded_server_selector.sv */
// Top level of the least loaded server selector: sequencer, flags and result register.
//
//   channel  direction  handshake             payload
//   req_     in         req_tvalid/tready     tdata fields, tlast sweep end, tuser command
//   rsp_     out        rsp_tvalid/tready     tdata found, selected index, health due
//   csr_     in         csr_valid/ready       csr_index, csr_data
//
// Dispatch: the scan covers n entries, n = active servers capped at MAX_SERVERS, and is skipped
// when n is zero. The scan reads one memory entry per cycle through the single read port,
// then writes back the winner if any entry is valid.
// Health report and unused command finish directly. Outcome: a relay failure reads the entry,
// then modifies and writes it back. Reset clears the written and invalid flags.
// A result waits in the output register; the next transaction finishes only once it is taken.
module least_loaded_server_selector #(
   parameter int MAX_SERVERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] server_index, [4] healthy, [36:5] reported_requests,
   // [68:37] reported_errors, [70:69] outcome, [71] zero
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,   // sweep_end
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] found, [4:1] selected_index, [5] health_due, [7:6] zero
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CW = $clog2(MAX_SERVERS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_WB   = 3'd2;
   localparam logic [2:0] ST_OMOD = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [4:0]             active_ff, active_in;
   logic [15:0]            interval_ff, interval_in;
   logic [15:0]            dcount_ff, dcount_in;
   logic [MAX_SERVERS-1:0] written_ff, written_in;
   logic [MAX_SERVERS-1:0] invalid_ff, invalid_in;
   logic [CW-1:0]          lim_ff, lim_in;
   logic [CW-1:0]          iss_ff, iss_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                   have_ff, have_in;
   logic [AW-1:0]          best_idx_ff, best_idx_in;
   logic [31:0]            best_req_ff, best_req_in;
   logic [31:0]            best_err_ff, best_err_in;
   logic [AW-1:0]          op_idx_ff, op_idx_in;
   logic                   found_ff, found_in;
   logic [3:0]             sel_ff, sel_in;
   logic                   due_ff, due_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   llss_pkg::entry_type    ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   llss_pkg::entry_type    ram_rd_data;
   llss_pkg::entry_type    cand;
   llss_pkg::entry_type    omod_entry;

   logic [1:0]             in_cmd;
   logic [3:0]             in_server_index;
   logic                   in_healthy;
   logic [31:0]            in_requests;
   logic [31:0]            in_errors;
   logic [1:0]             in_outcome;
   logic                   in_idx_ok;
   logic [AW-1:0]          in_addr;

   assign in_cmd          = req_tuser;
   assign in_server_index = req_tdata[3:0];
   assign in_healthy      = req_tdata[4];
   assign in_requests     = req_tdata[36:5];
   assign in_errors       = req_tdata[68:37];
   assign in_outcome      = req_tdata[70:69];
   assign in_idx_ok       = (32'(in_server_index) < MAX_SERVERS);
   assign in_addr         = AW'(in_server_index);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Entries never written since reset read as zero counts
   assign cand       = written_ff[cmp_idx_ff] ? ram_rd_data : '0;
   assign omod_entry = written_ff[op_idx_ff] ? ram_rd_data : '0;

   llss_ram #(
      .DEPTH (MAX_SERVERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      interval_in  = interval_ff;
      dcount_in    = dcount_ff;
      written_in   = written_ff;
      invalid_in   = invalid_ff;
      lim_in       = lim_ff;
      iss_in       = iss_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_req_in  = best_req_ff;
      best_err_in  = best_err_ff;
      op_idx_in    = op_idx_ff;
      found_in     = found_ff;
      sel_in       = sel_ff;
      due_in       = due_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      if (csr_valid) begin
         case (csr_index)
            llss_pkg::CSR_ACTIVE_SERVERS:   active_in = csr_data[4:0];
            llss_pkg::CSR_RECHECK_INTERVAL: interval_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               found_in  = 1'b0;
               sel_in    = '0;
               due_in    = 1'b0;
               op_idx_in = in_addr;
               state_in  = ST_FIN;
               case (in_cmd)
                  llss_pkg::CMD_DISPATCH: begin
                     due_in = (interval_ff != '0) && (dcount_ff == interval_ff);
                     if (dcount_ff != llss_pkg::DCOUNT_MAX) begin
                        dcount_in = dcount_ff + 16'd1;
                     end
                     lim_in  = (32'(active_ff) > MAX_SERVERS) ? CW'(MAX_SERVERS)
                                                              : CW'(active_ff);
                     iss_in  = '0;
                     have_in = 1'b0;
                     if (active_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  llss_pkg::CMD_HEALTH: begin
                     if (in_idx_ok) begin
                        if (in_healthy) begin
                           ram_wr_en            = 1'b1;
                           ram_wr_addr          = in_addr;
                           ram_wr_data.requests = in_requests;
                           ram_wr_data.errors   = in_errors;
                           written_in[in_addr]  = 1'b1;
                           invalid_in[in_addr]  = 1'b0;
                        end else begin
                           invalid_in[in_addr] = 1'b1;
                        end
                     end
                     if (req_tlast) begin
                        dcount_in = '0;
                     end
                  end
                  llss_pkg::CMD_OUTCOME: begin
                     if (in_idx_ok) begin
                        if (in_outcome == llss_pkg::OUT_CONNECT_FAIL) begin
                           invalid_in[in_addr] = 1'b1;
                        end else if (in_outcome == llss_pkg::OUT_RELAY_FAIL) begin
                           ram_rd_en   = 1'b1;
                           ram_rd_addr = in_addr;
                           state_in    = ST_OMOD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle; compare the entry read in the previous cycle
            if (iss_ff < lim_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = AW'(iss_ff);
               iss_in       = iss_ff + CW'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = AW'(iss_ff);
            end
            if (cmp_valid_ff && !invalid_ff[cmp_idx_ff]) begin
               if (!have_ff || (cand.requests < best_req_ff) ||
                   ((cand.requests == best_req_ff) && (cand.errors < best_err_ff))) begin
                  have_in     = 1'b1;
                  best_idx_in = cmp_idx_ff;
                  best_req_in = cand.requests;
                  best_err_in = cand.errors;
               end
            end
            if ((iss_ff == lim_ff) && !cmp_valid_ff) begin
               state_in = have_ff ? ST_WB : ST_FIN;
            end
         end
         ST_WB: begin
            ram_wr_en               = 1'b1;
            ram_wr_addr             = best_idx_ff;
            ram_wr_data.requests    = llss_pkg::sat_inc(best_req_ff);
            ram_wr_data.errors      = best_err_ff;
            written_in[best_idx_ff] = 1'b1;
            found_in                = 1'b1;
            sel_in                  = 4'(best_idx_ff);
            state_in                = ST_FIN;
         end
         ST_OMOD: begin
            ram_wr_en             = 1'b1;
            ram_wr_addr           = op_idx_ff;
            ram_wr_data.requests  = omod_entry.requests;
            ram_wr_data.errors    = llss_pkg::sat_inc(omod_entry.errors);
            written_in[op_idx_ff] = 1'b1;
            invalid_in[op_idx_ff] = 1'b1;
            state_in              = ST_FIN;
         end
         ST_FIN: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, due_ff, sel_ff, found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 5'd1;
         interval_ff  <= 16'd5;
         dcount_ff    <= '0;
         written_ff   <= '0;
         invalid_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         lim_ff       <= '0;
         iss_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         interval_ff  <= interval_in;
         dcount_ff    <= dcount_in;
         written_ff   <= written_in;
         invalid_ff   <= invalid_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         lim_ff       <= lim_in;
         iss_ff       <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_req_ff <= best_req_in;
      best_err_ff <= best_err_in;
      op_idx_ff   <= op_idx_in;
      found_ff    <= found_in;
      sel_ff      <= sel_in;
      due_ff      <= due_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_wr_en)
      else $error("memory written during a dispatch scan");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_ff <= lim_ff))
      else $error("scan issued past the active entries");

   a_wb_marks_written: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |=> written_ff[$past(best_idx_ff)])
      else $error("written flag not set after dispatch write back");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the finish step");

   a_winner_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |-> (have_ff && !invalid_ff[best_idx_ff]))
      else $error("dispatch chose an invalid entry");

endmodule

/* rtl/llss_ram.sv */
// Server count memory: one write port, one read port with registered data.
module llss_ram #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  llss_pkg::entry_type                    wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output llss_pkg::entry_type                    rd_data
);

   llss_pkg::entry_type mem [DEPTH];
   llss_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
